// File: src/pidc_pkg.sv
package pidc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 16;
  localparam int GAIN_W    = 32;
  localparam int ACC_W     = 32;
  localparam int LIM_W     = 15;
  localparam int MODE_W    = 5;
  localparam int PACK_W    = 48;
  localparam int ERR_W     = 18;
  localparam int DIFF_W    = 19;
  localparam int PROD_W    = 64;
  localparam int TERM_W    = 49;
  localparam int SUM_W     = 51;
  localparam int DEN_W     = 34;
  localparam int QUO_W     = 48;
  localparam int DIV_CNT_W = 6;
  localparam int IDX_W     = 3;

  localparam int MODE_ZERO_CROSS = 0;
  localparam int MODE_DEAD_ZONE  = 1;
  localparam int MODE_VAR_INT    = 2;
  localparam int MODE_SEPARATION = 3;
  localparam int MODE_D_ON_OUT   = 4;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(25000);
  localparam logic [QUO_W-1:0] TERM_MAX = {QUO_W{1'b1}};

  typedef enum logic [IDX_W-1:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_OLIM   = 3'd3,
    CFG_ILIM   = 3'd4,
    CFG_MODE   = 3'd5,
    CFG_THRESH = 3'd6,
    CFG_VARINT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] measured;
    logic signed [SAMPLE_W-1:0] setpoint;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    logic                       limited;
  } out_word_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]         olim;
    logic [LIM_W-1:0]         ilim;
    logic [MODE_W-1:0]        mode;
    logic [PACK_W-1:0]        thresh;
    logic [PACK_W-1:0]        varint;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic acc_mul_p;
    logic mul_i;
    logic mul_d;
    logic div_start;
    logic div_step;
    logic sep;
    logic sum;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } sts_t;

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] m;
    logic [QUO_W-1:0]  s;
    m = x[PROD_W-1] ? (~x + PROD_W'(1)) : x;
    s = (m > PROD_W'(TERM_MAX)) ? TERM_MAX : m[QUO_W-1:0];
    return x[PROD_W-1] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_thr(input logic [SAMPLE_W-1:0] t);
    return t[SAMPLE_W-1] ? {1'b0, {(SAMPLE_W-1){1'b1}}} : t;
  endfunction

endpackage

// File: src/pidc_ctrl.sv
module pidc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_free_i,
  input  pidc_pkg::sts_t sts_i,
  output pidc_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ACC  = 10'b0000000010,
    S_MI   = 10'b0000000100,
    S_MD   = 10'b0000001000,
    S_VCHK = 10'b0000010000,
    S_DIV  = 10'b0000100000,
    S_SEP  = 10'b0001000000,
    S_SUM  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_mul_p = 1'b1;
        state_d         = S_MI;
      end
      S_MI: begin
        cmd_o.mul_i = 1'b1;
        state_d     = S_MD;
      end
      S_MD: begin
        cmd_o.mul_d = 1'b1;
        state_d     = S_VCHK;
      end
      S_VCHK: begin
        if (sts_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_SEP;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SEP;
        end
      end
      S_SEP: begin
        cmd_o.sep = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/pidc_dp.sv
module pidc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidc_pkg::cfg_t     cfg_i,
  input  pidc_pkg::in_word_t in_data_i,
  input  pidc_pkg::cmd_t     cmd_i,
  output pidc_pkg::sts_t     sts_o,
  output pidc_pkg::out_word_t res_o
);

  localparam int SW = pidc_pkg::SAMPLE_W;
  localparam int EW = pidc_pkg::ERR_W;
  localparam int AW = pidc_pkg::ACC_W;
  localparam int GW = pidc_pkg::GAIN_W;
  localparam int TW = pidc_pkg::TERM_W;
  localparam int UW = pidc_pkg::SUM_W;
  localparam int NW = pidc_pkg::DEN_W;
  localparam int QW = pidc_pkg::QUO_W;
  localparam int FW = pidc_pkg::FRAC_W;
  localparam int CW = pidc_pkg::DIV_CNT_W;

  logic signed [EW-1:0] prev_e_q, e_q, e_new;
  logic signed [AW-1:0] acc_q, acc_old_q;
  logic signed [SW-1:0] last_q, before_q, drive_q;
  logic                 limited_q;
  logic signed [pidc_pkg::PROD_W-1:0] prod_q;
  logic signed [TW-1:0] p_q, i_q, d_q;
  logic signed [UW-1:0] sum_q;
  logic [NW-1:0]        den_q;
  logic [NW-1:0]        rem_q;
  logic [QW-1:0]        qsh_q;
  logic [CW-1:0]        cnt_q;
  logic                 ineg_q;

  logic signed [EW-1:0] e_raw, e_zc, z_s, dz_s, s_s, lo_s, hi_s;
  logic signed [AW:0]   acc_sum;
  logic signed [AW-1:0] acc_sat;
  logic signed [GW-1:0] mul_a, mul_b;
  logic signed [pidc_pkg::DIFF_W-1:0] diff;
  logic [EW-2:0]        e_mag;
  logic [QW-1:0]        i_mag;
  logic [NW:0]          trial;
  logic                 ge;
  logic [NW-1:0]        rem_n;
  logic [QW-1:0]        quo_n;
  logic signed [TW-1:0] ilim_s, i_clamped;
  logic                 sep_hit;
  logic signed [UW-1:0] olim_s, sum_c, rnd;
  logic                 over;

  assign z_s  = $signed({2'b00, pidc_pkg::sat_thr(cfg_i.thresh[15:0])});
  assign dz_s = $signed({2'b00, pidc_pkg::sat_thr(cfg_i.thresh[31:16])});
  assign s_s  = $signed({2'b00, pidc_pkg::sat_thr(cfg_i.thresh[47:32])});
  assign lo_s = EW'($signed(cfg_i.varint[15:0]));
  assign hi_s = EW'($signed(cfg_i.varint[31:16]));

  always_comb begin
    e_raw = EW'(in_data_i.setpoint) - EW'(in_data_i.measured);
    e_zc  = e_raw;
    if (cfg_i.mode[pidc_pkg::MODE_ZERO_CROSS]) begin
      priority if (e_raw >= z_s) begin
        e_zc = e_raw - (z_s <<< 1);
      end else if (e_raw <= -z_s) begin
        e_zc = e_raw + (z_s <<< 1);
      end else begin
        e_zc = e_raw;
      end
    end
    e_new = e_zc;
    if (cfg_i.mode[pidc_pkg::MODE_DEAD_ZONE] && e_zc <= dz_s && e_zc >= -dz_s) begin
      e_new = '0;
    end
  end

  always_comb begin
    acc_sum = (AW+1)'(acc_q) + (AW+1)'(e_q);
    if (acc_sum[AW] != acc_sum[AW-1]) begin
      acc_sat = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AW-1:0];
    end
  end

  always_comb begin
    if (cfg_i.mode[pidc_pkg::MODE_D_ON_OUT]) begin
      diff = pidc_pkg::DIFF_W'(last_q) - pidc_pkg::DIFF_W'(before_q);
    end else begin
      diff = pidc_pkg::DIFF_W'(e_q) - pidc_pkg::DIFF_W'(prev_e_q);
    end
    priority if (cmd_i.mul_i) begin
      mul_a = cfg_i.ki;
      mul_b = acc_q;
    end else if (cmd_i.mul_d) begin
      mul_a = cfg_i.kd;
      mul_b = GW'(diff);
    end else begin
      mul_a = cfg_i.kp;
      mul_b = GW'(e_q);
    end
  end

  assign e_mag = e_q[EW-1] ? (EW-1)'(-e_q) : e_q[EW-2:0];
  assign i_mag = i_q[TW-1] ? QW'(-i_q) : i_q[QW-1:0];

  assign sts_o.div_needed = cfg_i.mode[pidc_pkg::MODE_VAR_INT] && (e_q > hi_s || e_q < lo_s);
  assign sts_o.div_last   = (cnt_q == CW'(QW - 1));

  assign trial = {rem_q, qsh_q[QW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_n = ge ? NW'(trial - {1'b0, den_q}) : trial[NW-1:0];
  assign quo_n = {qsh_q[QW-2:0], ge};

  assign ilim_s = $signed(TW'({cfg_i.ilim, {FW{1'b0}}}));
  assign sep_hit = cfg_i.mode[pidc_pkg::MODE_SEPARATION] && (e_q > s_s || e_q < -s_s);

  always_comb begin
    priority if (i_q > ilim_s) begin
      i_clamped = ilim_s;
    end else if (i_q < -ilim_s) begin
      i_clamped = -ilim_s;
    end else begin
      i_clamped = i_q;
    end
  end

  assign olim_s = $signed(UW'({cfg_i.olim, {FW{1'b0}}}));

  always_comb begin
    over = 1'b1;
    priority if (sum_q > olim_s) begin
      sum_c = olim_s;
    end else if (sum_q < -olim_s) begin
      sum_c = -olim_s;
    end else begin
      sum_c = sum_q;
      over  = 1'b0;
    end
    rnd = sum_c + UW'(1 << (FW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_e_q <= '0;
      acc_q    <= '0;
      last_q   <= '0;
      before_q <= '0;
    end else begin
      if (cmd_i.acc_mul_p) begin
        acc_q <= acc_sat;
      end
      if (cmd_i.sep && sep_hit) begin
        acc_q <= acc_old_q;
      end
      if (cmd_i.fin) begin
        prev_e_q <= e_q;
        before_q <= last_q;
        last_q   <= rnd[FW+SW-1:FW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e_q       <= e_new;
      acc_old_q <= acc_q;
    end
    if (cmd_i.acc_mul_p || cmd_i.mul_i || cmd_i.mul_d) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.mul_i) begin
      p_q <= pidc_pkg::sat_term(prod_q);
    end
    if (cmd_i.mul_d) begin
      i_q   <= pidc_pkg::sat_term(prod_q);
      den_q <= NW'(cfg_i.varint[47:32] * e_mag) + NW'(1 << FW);
    end
    if (cmd_i.div_start) begin
      d_q    <= pidc_pkg::sat_term(prod_q);
      rem_q  <= NW'(i_mag[QW-1:QW-FW]);
      qsh_q  <= {i_mag[QW-FW-1:0], {FW{1'b0}}};
      cnt_q  <= '0;
      ineg_q <= i_q[TW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_n;
      qsh_q <= quo_n;
      cnt_q <= cnt_q + CW'(1);
      if (sts_o.div_last) begin
        i_q <= ineg_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
      end
    end else if (cmd_i.sep) begin
      i_q <= sep_hit ? '0 : i_clamped;
    end
    if (cmd_i.sep && !sts_o.div_needed) begin
      d_q <= pidc_pkg::sat_term(prod_q);
    end
    if (cmd_i.sum) begin
      sum_q <= UW'(p_q) + UW'(i_q) + UW'(d_q);
    end
    if (cmd_i.fin) begin
      drive_q   <= rnd[FW+SW-1:FW];
      limited_q <= over;
    end
  end

  assign res_o.drive   = drive_q;
  assign res_o.limited = limited_q;

endmodule

// File: src/pid_controller_with_options.sv
// Positional PID controller on signed 16-bit samples with Q16.16 gains. An accepted
// word passes through states ACC, MI, MD, VCHK, SEP, SUM and FIN to a ready result;
// when variable-speed integral scales the integral term, DIV runs a radix-2 divider.
// One 32x32 multiplier is shared by the three terms, one product a cycle. The block
// takes one word at a time; a finished result waits in the output register while the
// next word is taken. Configuration writes are always ready and must be made while idle.
module pid_controller_with_options (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pidc_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pidc_pkg::out_word_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pidc_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [pidc_pkg::PACK_W-1:0]   cfg_data_i
);

  pidc_pkg::cfg_t      cfg_q;
  pidc_pkg::cmd_t      cmd;
  pidc_pkg::sts_t      sts;
  pidc_pkg::out_word_t res;
  pidc_pkg::out_word_t out_q;
  logic                out_valid_q;
  logic                busy;
  logic                out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp     <= '0;
      cfg_q.ki     <= '0;
      cfg_q.kd     <= '0;
      cfg_q.olim   <= pidc_pkg::LIMIT_RESET;
      cfg_q.ilim   <= pidc_pkg::LIMIT_RESET;
      cfg_q.mode   <= '0;
      cfg_q.thresh <= '0;
      cfg_q.varint <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pidc_pkg::cfg_idx_e'(cfg_index_i))
        pidc_pkg::CFG_KP:     cfg_q.kp     <= cfg_data_i[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::CFG_KI:     cfg_q.ki     <= cfg_data_i[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::CFG_KD:     cfg_q.kd     <= cfg_data_i[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::CFG_OLIM:   cfg_q.olim   <= cfg_data_i[pidc_pkg::LIM_W-1:0];
        pidc_pkg::CFG_ILIM:   cfg_q.ilim   <= cfg_data_i[pidc_pkg::LIM_W-1:0];
        pidc_pkg::CFG_MODE:   cfg_q.mode   <= cfg_data_i[pidc_pkg::MODE_W-1:0];
        pidc_pkg::CFG_THRESH: cfg_q.thresh <= cfg_data_i;
        pidc_pkg::CFG_VARINT: cfg_q.varint <= cfg_data_i;
        default:              cfg_q.mode   <= cfg_q.mode;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  pidc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  pidc_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (res)
  );

  assign in_stall_o = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a word without going busy");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no word in flight");

  a_limited_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.limited |->
      (out_data_o.drive == {1'b0, cfg_q.olim}) ||
      (out_data_o.drive == -{1'b0, cfg_q.olim}))
    else $error("clamped drive is not at the output limit");

endmodule
